// ----- hw/rtl/mrc_pkg.sv -----
`timescale 1ns / 1ps

package mrc_pkg;

  localparam int MAX_FRAME  = 256;
  localparam int CNT_W      = $clog2(MAX_FRAME + 1);
  localparam int MIN_FRAME  = 5;
  localparam int CFG_DATA_W = 9;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [6:0] EXP_FUNC_RESET  = 7'd3;
  localparam logic [8:0] REPLY_LEN_RESET = 9'd7;

  // byte positions inside the frame
  localparam logic [CNT_W-1:0] POS_FUNC   = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_EXC    = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_VAL_HI = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_VAL_LO = CNT_W'(4);

  localparam int FUNC_EXC_BIT = 7;

  typedef enum logic [2:0] {
    ST_SHORT     = 3'd0,
    ST_CRC_ERR   = 3'd1,
    ST_READ      = 3'd2,
    ST_EXCEPTION = 3'd3,
    ST_OTHER     = 3'd4,
    ST_OVERLONG  = 3'd5
  } status_t;

  typedef enum logic {
    CFG_EXPECTED_FUNCTION = 1'b0,
    CFG_REPLY_LENGTH      = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [6:0] expected_function;
    logic [8:0] reply_length;
  } mrc_cfg_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] reg_value;
    logic [7:0]         exception_code;
    logic [8:0]         frame_length;
    logic [15:0]        computed_crc;
    logic [15:0]        received_crc;
  } mrc_result_t;

  // byte-wide update of the reflected crc-16
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/mrc_in_if.sv -----
`timescale 1ns / 1ps

interface mrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/mrc_out_if.sv -----
`timescale 1ns / 1ps

interface mrc_out_if import mrc_pkg::*; ;
  logic               valid;
  logic               ready;
  status_t            status;
  logic signed [15:0] reg_value;
  logic [7:0]         exception_code;
  logic [8:0]         frame_length;
  logic [15:0]        computed_crc;
  logic [15:0]        received_crc;

  modport source (output valid, output status, output reg_value, output exception_code,
                  output frame_length, output computed_crc, output received_crc,
                  input ready);
  modport sink (input valid, input status, input reg_value, input exception_code,
                input frame_length, input computed_crc, input received_crc,
                output ready);
endinterface

// ----- hw/rtl/mrc_cfg_if.sv -----
`timescale 1ns / 1ps

interface mrc_cfg_if import mrc_pkg::*; ;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/mrc_frame.sv -----
`timescale 1ns / 1ps

module mrc_frame import mrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic        last_byte,
  input  mrc_cfg_t    cfg,
  output mrc_result_t result
);

  logic [15:0]           crc_r, crc_nxt;
  logic [1:0][7:0]       dly_r, dly_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [7:0]            func_r, func_nxt;
  logic [2:0][7:0]       hdr_r, hdr_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  crc_ok;
  logic                  long_enough;

  // frame state after this word, before any end-of-frame clear
  always_comb begin
    crc_nxt  = (cnt_r >= CNT_W'(2)) ? crc_feed(crc_r, dly_r[0]) : crc_r;
    dly_nxt  = {rx_byte, dly_r[1]};
    func_nxt = func_r;
    hdr_nxt  = hdr_r;
    case (cnt_r)
      POS_FUNC:   func_nxt   = rx_byte;
      POS_EXC:    hdr_nxt[0] = rx_byte;
      POS_VAL_HI: hdr_nxt[1] = rx_byte;
      POS_VAL_LO: hdr_nxt[2] = rx_byte;
      default:    ;
    endcase
    if (cnt_r >= CNT_W'(MAX_FRAME)) begin
      ovf_nxt = 1'b1;
      cnt_nxt = cnt_r;
    end else begin
      ovf_nxt = ovf_r;
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  assign long_enough = (cnt_nxt >= CNT_W'(MIN_FRAME));
  assign crc_ok      = (crc_nxt == {dly_nxt[1], dly_nxt[0]});

  always_comb begin
    result                = '0;
    result.frame_length   = 9'(cnt_nxt);
    if (ovf_nxt || long_enough) begin
      result.computed_crc = crc_nxt;
      result.received_crc = {dly_nxt[1], dly_nxt[0]};
    end
    if (ovf_nxt) begin
      result.status = ST_OVERLONG;
    end else if (!long_enough) begin
      result.status = ST_SHORT;
    end else if (!crc_ok) begin
      result.status = ST_CRC_ERR;
    end else if (func_nxt == {1'b0, cfg.expected_function} &&
                 9'(cnt_nxt) == cfg.reply_length) begin
      result.status    = ST_READ;
      result.reg_value = {hdr_nxt[1], hdr_nxt[2]};
    end else if (func_nxt[FUNC_EXC_BIT]) begin
      result.status         = ST_EXCEPTION;
      result.exception_code = hdr_nxt[0];
    end else begin
      result.status = ST_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      crc_r  <= CRC_INIT;
      dly_r  <= '0;
      cnt_r  <= '0;
      func_r <= '0;
      hdr_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (step) begin
      crc_r  <= crc_nxt;
      dly_r  <= dly_nxt;
      cnt_r  <= cnt_nxt;
      func_r <= func_nxt;
      hdr_r  <= hdr_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

// ----- hw/rtl/modbus_rtu_reply_checker.sv -----
// Modbus RTU reply checker: takes a reply frame one byte per word, with last_byte set on the
// final byte, and returns one verdict word per frame (too short, crc error, read reply with
// its signed value, exception with its code, other reply, or overlong). The crc-16 runs over
// all bytes but the final two, which are compared low byte first. Throughput is one byte per
// clock while no waiting verdict holds a last byte; a verdict is offered from the result
// register once the last byte has passed the input register, around the byte-wide unrolled
// crc update. A waiting verdict stalls only the next frame's last byte. Config writes are
// always taken and apply to later verdicts.
`timescale 1ns / 1ps

module modbus_rtu_reply_checker import mrc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mrc_in_if.sink    in_item,
  mrc_out_if.source out_item,
  mrc_cfg_if.sink   cfg_wr
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_adv;
  logic        in_acc;
  logic        out_valid_r, out_valid_nxt;
  mrc_result_t out_r;
  mrc_result_t verdict;
  mrc_cfg_t    cfg_r;

  // a last word waits only if the result register is still full
  assign s1_adv        = s1_valid_r && (!s1_last_r || !out_valid_r || out_item.ready);
  assign in_item.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_item.valid && in_item.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  mrc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .rx_byte   (s1_byte_r),
    .last_byte (s1_last_r),
    .cfg       (cfg_r),
    .result    (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_item.rx_byte;
      s1_last_r <= in_item.last_byte;
    end
    if (s1_adv && s1_last_r) begin
      out_r <= verdict;
    end
  end

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_function <= EXP_FUNC_RESET;
      cfg_r.reply_length      <= REPLY_LEN_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_EXPECTED_FUNCTION: cfg_r.expected_function <= cfg_wr.data[6:0];
        CFG_REPLY_LENGTH:      cfg_r.reply_length      <= cfg_wr.data[8:0];
        default:               ;
      endcase
    end
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.status         = out_r.status;
  assign out_item.reg_value      = out_r.reg_value;
  assign out_item.exception_code = out_r.exception_code;
  assign out_item.frame_length   = out_r.frame_length;
  assign out_item.computed_crc   = out_r.computed_crc;
  assign out_item.received_crc   = out_r.received_crc;

endmodule

// ----- hw/rtl/mrc_checker.sv -----
`timescale 1ns / 1ps

module mrc_checker import mrc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input status_t     out_status,
  input logic [15:0] out_reg_value,
  input logic [7:0]  out_exception_code,
  input logic [8:0]  out_frame_length,
  input logic [15:0] out_computed_crc,
  input logic [15:0] out_received_crc
);

  // a stalled word keeps its verdict
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_frame_length) && $stable(out_computed_crc))
    else $error("result word changed while stalled");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_READ || out_reg_value == 16'd0) &&
      (out_status == ST_EXCEPTION || out_exception_code == 8'd0))
    else $error("value or exception code set for the wrong verdict");

  a_crc_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_READ || out_status == ST_EXCEPTION ||
      out_status == ST_OTHER) |-> out_computed_crc == out_received_crc)
    else $error("accepted frame with mismatched crc");

  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SHORT |-> out_frame_length < 9'(MIN_FRAME) &&
      out_computed_crc == 16'd0 && out_received_crc == 16'd0)
    else $error("short frame verdict inconsistent");

  a_overlong: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERLONG |-> out_frame_length == 9'(MAX_FRAME))
    else $error("overlong frame length not saturated");

endmodule

bind modbus_rtu_reply_checker mrc_checker u_mrc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_item.valid),
  .out_ready          (out_item.ready),
  .out_status         (out_item.status),
  .out_reg_value      (out_item.reg_value),
  .out_exception_code (out_item.exception_code),
  .out_frame_length   (out_item.frame_length),
  .out_computed_crc   (out_item.computed_crc),
  .out_received_crc   (out_item.received_crc)
);

// ----- sim/modbus_rtu_reply_checker_test.sv -----
`timescale 1ns / 1ps

module modbus_rtu_reply_checker_test;
  import mrc_pkg::*;

  typedef struct {
    int          len;
    logic [7:0]  addr;
    logic [7:0]  fn;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  b4;
    bit          crc_ok;
    bit          typed;
    mrc_result_t want;
  } frame_row_t;

  logic clk;
  logic rst_n;

  mrc_in_if  in_item();
  mrc_out_if out_item();
  mrc_cfg_if cfg_wr();

  modbus_rtu_reply_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .cfg_wr   (cfg_wr)
  );

  // predictor copy of the registers and the frame state
  logic [6:0]  want_fn;
  logic [8:0]  want_len;
  logic [15:0] crc_acc;
  logic [7:0]  tail_bytes[2];
  int          byte_cnt;
  logic [7:0]  fn_byte;
  logic [7:0]  hdr_bytes[3];
  bit          too_long;

  mrc_result_t pending_verdicts[$];
  logic [7:0]  frame_bytes[$];
  frame_row_t  dir_rows[6];
  int          idle_pct;
  int          stall_pct;
  int          items_sent;
  int          mismatches;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    crc_acc       = CRC_INIT;
    tail_bytes[0] = 8'h00;
    tail_bytes[1] = 8'h00;
    byte_cnt      = 0;
    fn_byte       = 8'h00;
    for (int i = 0; i < 3; i++) hdr_bytes[i] = 8'h00;
    too_long      = 1'b0;
  endfunction

  // the last two bytes stay in the tail until the frame end shows they are the crc
  task automatic predict_verdict(input logic [7:0] b, input bit is_last, output bit done,
                                 output mrc_result_t v);
    int pos;
    pos  = byte_cnt;
    done = 1'b0;
    v    = '0;
    if (pos >= 2) crc_acc = crc16_step(crc_acc, tail_bytes[0]);
    tail_bytes[0] = tail_bytes[1];
    tail_bytes[1] = b;
    if (pos == 1) begin
      fn_byte = b;
    end else if (pos >= 2 && pos <= 4) begin
      hdr_bytes[pos-2] = b;
    end
    if (pos >= MAX_FRAME) too_long = 1'b1;
    else byte_cnt = pos + 1;
    if (is_last) begin
      done = 1'b1;
      v.frame_length = 9'(byte_cnt);
      if (too_long || byte_cnt >= MIN_FRAME) begin
        v.computed_crc = crc_acc;
        v.received_crc = {tail_bytes[1], tail_bytes[0]};
      end
      if (too_long) begin
        v.status = ST_OVERLONG;
      end else if (byte_cnt < MIN_FRAME) begin
        v.status = ST_SHORT;
      end else if (v.computed_crc != v.received_crc) begin
        v.status = ST_CRC_ERR;
      end else if (fn_byte == {1'b0, want_fn} && byte_cnt == int'(want_len)) begin
        v.status    = ST_READ;
        v.reg_value = {hdr_bytes[1], hdr_bytes[2]};
      end else if (fn_byte[7]) begin
        v.status         = ST_EXCEPTION;
        v.exception_code = hdr_bytes[0];
      end else begin
        v.status = ST_OTHER;
      end
      clear_frame();
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0h got %0h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    mrc_result_t want;
    mrc_result_t got;
    if (rst_n && out_item.valid && out_item.ready) begin
      got = {out_item.status, out_item.reg_value, out_item.exception_code,
             out_item.frame_length, out_item.computed_crc, out_item.received_crc};
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t ns: verdict with none expected, status %0d length %0d", $time,
                 got.status, got.frame_length);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("reg_value", want.reg_value, got.reg_value);
        check_field("exception_code", 16'(want.exception_code), 16'(got.exception_code));
        check_field("frame_length", 16'(want.frame_length), 16'(got.frame_length));
        check_field("computed_crc", want.computed_crc, got.computed_crc);
        check_field("received_crc", want.received_crc, got.received_crc);
      end
    end
  end

  always @(posedge clk) begin
    out_item.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // fills frame_bytes; from 5 bytes on the final two carry the crc, good or spoiled
  task automatic build_frame(input int len, input logic [7:0] addr, input logic [7:0] fn,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input logic [7:0] b4, input bit crc_ok);
    logic [15:0] crc;
    frame_bytes.delete();
    for (int i = 0; i < len; i++) begin
      case (i)
        0: frame_bytes.push_back(addr);
        1: frame_bytes.push_back(fn);
        2: frame_bytes.push_back(b2);
        3: frame_bytes.push_back(b3);
        4: frame_bytes.push_back(b4);
        default: frame_bytes.push_back(8'($urandom));
      endcase
    end
    if (len >= MIN_FRAME) begin
      crc = CRC_INIT;
      for (int i = 0; i < len - 2; i++) crc = crc16_step(crc, frame_bytes[i]);
      if (!crc_ok) crc ^= 16'($urandom_range(1, 65535));
      frame_bytes[len-2] = crc[7:0];
      frame_bytes[len-1] = crc[15:8];
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit is_last, output bit done,
                           output mrc_result_t v);
    if ($urandom_range(99) < idle_pct) begin
      in_item.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_item.valid     <= 1'b1;
    in_item.rx_byte   <= b;
    in_item.last_byte <= is_last;
    do @(posedge clk); while (!in_item.ready);
    items_sent++;
    predict_verdict(b, is_last, done, v);
  endtask

  task automatic send_frame(input bit typed, input mrc_result_t typed_v);
    bit          done;
    mrc_result_t v;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, done, v);
      if (done) pending_verdicts.push_back(typed ? typed_v : v);
    end
  endtask

  function automatic logic [7:0] pick_value_byte(input bit hi);
    case ($urandom_range(9))
      0: return hi ? 8'h80 : 8'h00;
      1: return hi ? 8'h7F : 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed replies with random content, the rest broken or noise
  task automatic random_frame();
    int          kind;
    int          len;
    logic [7:0]  fn;
    bit          crc_ok;
    mrc_result_t none;
    none   = '0;
    kind   = $urandom_range(99);
    crc_ok = 1'b1;
    fn     = 8'($urandom);
    if (kind < 35) begin
      fn  = {1'b0, want_fn};
      len = (want_len >= MIN_FRAME && want_len <= MAX_FRAME) ? int'(want_len)
                                                             : $urandom_range(5, 12);
    end else if (kind < 50) begin
      fn  = 8'h80 | 8'($urandom_range(0, 127));
      len = $urandom_range(5, 9);
    end else if (kind < 65) begin
      fn  = 8'($urandom_range(0, 127));
      len = $urandom_range(5, 12);
    end else if (kind < 80) begin
      if ($urandom_range(1)) fn = {1'b0, want_fn};
      len    = (want_len <= 12 && $urandom_range(1)) ? int'(want_len) : $urandom_range(5, 12);
      crc_ok = 1'b0;
    end else if (kind < 90) begin
      len = $urandom_range(1, 4);
    end else begin
      len    = $urandom_range(1, 12);
      crc_ok = $urandom_range(1);
    end
    build_frame(len, 8'($urandom), fn, 8'($urandom), pick_value_byte(1'b1),
                pick_value_byte(1'b0), crc_ok);
    send_frame(1'b0, none);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [8:0] val);
    in_item.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // a frame end may still sit in the pipeline
    repeat (6) @(posedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= val;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    if (idx == CFG_EXPECTED_FUNCTION) want_fn = val[6:0];
    else want_len = val;
  endtask

  initial begin
    #2_000_000;
    $display("modbus_rtu_reply_checker_test NOT OK");
    $finish;
  end

  initial begin
    mrc_result_t none;
    logic [8:0]  fn_data;
    logic [8:0]  len_data;
    int          budget;
    int          start;
    none              = '0;
    rst_n             = 1'b0;
    in_item.valid     = 1'b0;
    in_item.rx_byte   = 8'h00;
    in_item.last_byte = 1'b0;
    out_item.ready    = 1'b0;
    cfg_wr.valid      = 1'b0;
    cfg_wr.index      = CFG_EXPECTED_FUNCTION;
    cfg_wr.data       = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    items_sent        = 0;
    mismatches        = 0;
    want_fn           = EXP_FUNC_RESET;
    want_len          = REPLY_LEN_RESET;
    clear_frame();

    // len, addr, fn, b2, b3, b4, crc ok, typed, typed verdict
    dir_rows = '{
      '{1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
        '{ST_SHORT, 16'sd0, 8'd0, 9'd1, 16'd0, 16'd0}},
      '{4, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, 1'b1, 1'b1,
        '{ST_SHORT, 16'sd0, 8'd0, 9'd4, 16'd0, 16'd0}},
      '{5, 8'h01, 8'h83, 8'h02, 8'h00, 8'h00, 1'b1, 1'b0, '0},
      '{7, 8'hFF, 8'h03, 8'h02, 8'h80, 8'h00, 1'b1, 1'b0, '0},
      '{5, 8'h01, 8'h03, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, '0},
      '{5, 8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      build_frame(dir_rows[i].len, dir_rows[i].addr, dir_rows[i].fn, dir_rows[i].b2,
                  dir_rows[i].b3, dir_rows[i].b4, dir_rows[i].crc_ok);
      send_frame(dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      // phase 0 keeps the reset settings
      if (ph > 0) begin
        case (ph)
          1: begin fn_data = 9'h000; len_data = 9'd5;   end
          2: begin fn_data = 9'h07F; len_data = 9'd256; end
          3: begin fn_data = 9'h183; len_data = 9'd7;   end
          5: begin fn_data = 9'h110; len_data = 9'd8;   end
          6: begin fn_data = 9'($urandom); len_data = 9'd229; end
          7: begin fn_data = 9'h003; len_data = 9'd7;   end
          default: begin fn_data = 9'($urandom); len_data = 9'($urandom_range(5, 16)); end
        endcase
        cfg_write(CFG_EXPECTED_FUNCTION, fn_data);
        cfg_write(CFG_REPLY_LENGTH, len_data);
      end
      if (ph == 2) begin
        // full-size read reply, then one byte past the maximum
        build_frame(MAX_FRAME, 8'h01, 8'h7F, 8'h02, 8'h12, 8'h34, 1'b1);
        send_frame(1'b0, none);
        build_frame(MAX_FRAME + 1, 8'h01, 8'h83, 8'h05, 8'h00, 8'h00, 1'b1);
        send_frame(1'b0, none);
      end
      if (ph == 5) begin
        build_frame($urandom_range(MAX_FRAME + 2, 300), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(1));
        send_frame(1'b0, none);
      end
      budget = 150;
      start  = items_sent;
      while (items_sent - start < budget) random_frame();
    end

    in_item.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("modbus_rtu_reply_checker_test OK");
    end else begin
      $display("modbus_rtu_reply_checker_test NOT OK");
    end
    $finish;
  end

endmodule
